FILE: hw/rtl/segment_point_contact_penalty_macros.svh
// assertion macros for the contact penalty block
// needs clk and rst_n in the scope where a macro is used
`ifndef SEGMENT_POINT_CONTACT_PENALTY_MACROS_SVH
`define SEGMENT_POINT_CONTACT_PENALTY_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SPCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/spcp_pkg.sv
// types, constants and rounding helper for the contact penalty block
// no dependencies
package spcp_pkg;

    localparam int SQ_STAGES  = 8;
    localparam int DIV_STAGES = 8;
    localparam int STEPS      = 4;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic               penetrating;
        logic               degenerate;
        logic        [62:0] penalty;
        logic signed [31:0] gap;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] grad_surface_x;
        logic signed [31:0] grad_surface_y;
        logic        [30:0] hess_xx;
        logic signed [31:0] hess_xy;
        logic        [30:0] hess_yy;
    } out_item_t;

    // per-item data that rides along the normalize, root and divide stages
    typedef struct packed {
        logic               degen;
        logic               neg_x;
        logic               neg_y;
        logic signed [32:0] e0;
        logic signed [32:0] e1;
        logic        [30:0] a0;
        logic        [30:0] a1;
    } side_t;

    // drop 30 fraction bits, round half away from zero, clamp to 32 bits;
    // flip negates the value first
    function automatic logic [31:0] round_sat32(input logic signed [63:0] v,
                                                input logic flip);
        logic        neg;
        logic [63:0] m;
        logic [63:0] t;
        logic [33:0] r;
        logic [33:0] rn;
        neg = v[63] ^ flip;
        m   = v[63] ? (~v + 64'd1) : v;
        t   = m + (64'd1 << 29);
        r   = t[63:30];
        if (neg) begin
            if (r > 34'h0_8000_0000) r = 34'h0_8000_0000;
            rn = ~r + 34'd1;
            return rn[31:0];
        end
        if (r > 34'h0_7FFF_FFFF) r = 34'h0_7FFF_FFFF;
        return r[31:0];
    endfunction

endpackage

FILE: hw/rtl/spcp_if.sv
// valid/ready channel interfaces for contact triples and results
// depends on spcp_pkg
interface spcp_in_if import spcp_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spcp_out_if import spcp_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/spcp_sqrt_stage.sv
// one stage of the pipelined integer square root, four result bits
// depends on spcp_pkg
module spcp_sqrt_stage import spcp_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] s_in,
    input  logic [35:0] rem_in,
    input  logic [31:0] root_in,
    output logic [62:0] s_reg,
    output logic [35:0] rem_reg,
    output logic [31:0] root_reg
);

    logic [35:0] rem_next;
    logic [31:0] root_next;

    always_comb
    begin
        logic [63:0] s64;
        logic [35:0] t;
        logic [35:0] trial;
        s64       = {1'b0, s_in};
        rem_next  = rem_in;
        root_next = root_in;
        for (int j = 0; j < STEPS; j++)
        begin
            t     = {rem_next[33:0], s64[63 - 2 * (STAGE * STEPS + j) -: 2]};
            trial = {2'b00, root_next, 2'b01};
            if (t >= trial)
            begin
                rem_next  = t - trial;
                root_next = {root_next[30:0], 1'b1};
            end
            else
            begin
                rem_next  = t;
                root_next = {root_next[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

FILE: hw/rtl/spcp_div_stage.sv
// one stage of the pipelined restoring divider, four quotient bits
// depends on spcp_pkg
module spcp_div_stage import spcp_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [61:0] num_in,
    input  logic [31:0] den_in,
    input  logic [31:0] rem_in,
    input  logic [31:0] q_in,
    output logic [61:0] num_reg,
    output logic [31:0] den_reg,
    output logic [31:0] rem_reg,
    output logic [31:0] q_reg
);

    logic [31:0] rem_next;
    logic [31:0] q_next;

    always_comb
    begin
        logic [32:0] t;
        logic [32:0] diff;
        rem_next = rem_in;
        q_next   = q_in;
        for (int j = 0; j < STEPS; j++)
        begin
            t    = {rem_next, num_in[31 - (STAGE * STEPS + j)]};
            diff = t - {1'b0, den_in};
            if (t >= {1'b0, den_in})
            begin
                rem_next = diff[31:0];
                q_next   = {q_next[30:0], 1'b1};
            end
            else
            begin
                rem_next = t[31:0];
                q_next   = {q_next[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_in;
            den_reg <= den_in;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

FILE: hw/rtl/segment_point_contact_penalty.sv
// top level: 2d node-to-segment contact gap, penalty, gradient and hessian
// depends on spcp_pkg, spcp_if, spcp_sqrt_stage, spcp_div_stage and the macros header
//
// usage
//   item   : contact triple (two surface nodes, one point), q15.16, valid/ready
//   result : flags, penalty, gap, unit normal, gradient and hessian block
//   a transfer happens on a rising edge with valid and ready both high
// depth and throughput
//   28 register stages; one item per cycle sustained, with no gaps, as long
//   as no stall holds the pipe (see the stall notes below)
//   depth is set by the square root (8 stages of 4 bits) and the normal
//   divides (8 stages of 4 quotient bits) that sit in series
// stall
//   the whole pipe advances together; when result.valid is high and
//   result.ready low, item.ready drops and every stage holds, nothing lost
// reset
//   rst_n clears all stage valid bits at once; the pipe is empty and ready
//   in the first cycle after reset
`include "segment_point_contact_penalty_macros.svh"
module segment_point_contact_penalty import spcp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    spcp_in_if.sink     item,
    spcp_out_if.source  result
);

    localparam int NST     = 28;
    localparam int SQ_BASE = 5;
    localparam int NUM_ST  = SQ_BASE + SQ_STAGES;
    localparam int NSIDE   = 20;

    logic en;
    logic valid_reg [NST];

    // stage 1: differences
    logic signed [32:0] d0_reg, d1_reg, e0_s1_reg, e1_s1_reg;
    // stage 2: magnitudes
    logic [32:0]        m0_reg, m1_reg;
    logic               big_next;
    logic [4:0]         lsh_next;
    side_t              side2_reg;
    side_t              side3_next;
    // side data from normalize through divide
    side_t              side_reg [NSIDE];
    // stage 4/5: squares and sum
    logic [61:0]        sq0_reg, sq1_reg;
    logic [62:0]        s_reg;
    // root chain
    logic [62:0]        sq_s   [SQ_STAGES + 1];
    logic [35:0]        sq_rem [SQ_STAGES + 1];
    logic [31:0]        sq_root[SQ_STAGES + 1];
    // divide chains
    logic [61:0]        dv_num [2][DIV_STAGES + 1];
    logic [31:0]        dv_den [2][DIV_STAGES + 1];
    logic [31:0]        dv_rem [2][DIV_STAGES + 1];
    logic [31:0]        dv_q   [2][DIV_STAGES + 1];
    // back end
    logic signed [31:0] n0_reg, n1_reg, n0_p1_reg, n1_p1_reg, n0_p2_reg, n1_p2_reg;
    logic signed [31:0] n0_p3_reg, n1_p3_reg, n0_p4_reg, n1_p4_reg;
    logic signed [32:0] e0_n_reg, e1_n_reg;
    logic               dg_n_reg, dg_p1_reg, dg_p2_reg, dg_p3_reg, dg_p4_reg;
    logic signed [64:0] pr0_reg, pr1_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] gap_p3_reg, gap_p4_reg;
    logic [63:0]        pen_reg;
    logic signed [63:0] ng0_reg, ng1_reg, hxx_reg, hxy_reg, hyy_reg;
    logic [31:0]        gm_next;
    out_item_t          out_reg;
    out_item_t          out_next;

    // pipe moves whenever the output slot is free or being taken
    assign en          = !valid_reg[NST-1] || result.ready;
    assign item.ready  = en;
    assign result.valid = valid_reg[NST-1];
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++) valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= item.valid;
            for (int i = 1; i < NST; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    // leading one search on the joint magnitude for normalization
    always_comb
    begin
        logic [32:0] o;
        o        = m0_reg | m1_reg;
        lsh_next = '0;
        for (int p = 0; p < 31; p++)
        begin
            if (o[p]) lsh_next = 5'(30 - p);
        end
    end

    assign big_next = m0_reg[32] | m0_reg[31] | m1_reg[32] | m1_reg[31];

    // stage 3 input: larger magnitude into [2^30, 2^31)
    always_comb
    begin
        side3_next = side2_reg;
        if (big_next)
        begin
            side3_next.a0 = m0_reg[31:1];
            side3_next.a1 = m1_reg[31:1];
        end
        else
        begin
            side3_next.a0 = m0_reg[30:0] << lsh_next;
            side3_next.a1 = m1_reg[30:0] << lsh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: segment and point offsets
            d0_reg    <= {item.data.second_x[31], item.data.second_x}
                       - {item.data.first_x[31], item.data.first_x};
            d1_reg    <= {item.data.second_y[31], item.data.second_y}
                       - {item.data.first_y[31], item.data.first_y};
            e0_s1_reg <= {item.data.point_x[31], item.data.point_x}
                       - {item.data.first_x[31], item.data.first_x};
            e1_s1_reg <= {item.data.point_y[31], item.data.point_y}
                       - {item.data.first_y[31], item.data.first_y};

            // stage 2: normal direction (dy, -dx) as magnitudes plus signs
            m0_reg          <= d1_reg[32] ? 33'(-d1_reg) : 33'(d1_reg);
            m1_reg          <= d0_reg[32] ? 33'(-d0_reg) : 33'(d0_reg);
            side2_reg.degen <= (d0_reg == '0) && (d1_reg == '0);
            side2_reg.neg_x <= d1_reg[32];
            side2_reg.neg_y <= !d0_reg[32] && (d0_reg != '0);
            side2_reg.e0    <= e0_s1_reg;
            side2_reg.e1    <= e1_s1_reg;
            side2_reg.a0    <= '0;
            side2_reg.a1    <= '0;

            // stage 3: normalized magnitudes
            side_reg[0] <= side3_next;
            for (int i = 1; i < NSIDE; i++) side_reg[i] <= side_reg[i-1];

            // stage 4/5: sum of squares
            sq0_reg <= side_reg[0].a0 * side_reg[0].a0;
            sq1_reg <= side_reg[0].a1 * side_reg[0].a1;
            s_reg   <= {1'b0, sq0_reg} + {1'b0, sq1_reg};

            // numerator a * 2^30 + r / 2 for the rounded divide
            dv_num[0][0] <= {side_reg[NUM_ST-3].a0, 30'd0} + 62'(sq_root[SQ_STAGES] >> 1);
            dv_num[1][0] <= {side_reg[NUM_ST-3].a1, 30'd0} + 62'(sq_root[SQ_STAGES] >> 1);
            dv_den[0][0] <= sq_root[SQ_STAGES];
            dv_den[1][0] <= sq_root[SQ_STAGES];

            // normal: clamp to one, apply signs
            n0_reg   <= side_reg[NSIDE-1].neg_x
                      ? -$signed(dv_q[0][DIV_STAGES] > 32'h4000_0000 ? 32'h4000_0000
                                                                    : dv_q[0][DIV_STAGES])
                      : $signed(dv_q[0][DIV_STAGES] > 32'h4000_0000 ? 32'h4000_0000
                                                                   : dv_q[0][DIV_STAGES]);
            n1_reg   <= side_reg[NSIDE-1].neg_y
                      ? -$signed(dv_q[1][DIV_STAGES] > 32'h4000_0000 ? 32'h4000_0000
                                                                    : dv_q[1][DIV_STAGES])
                      : $signed(dv_q[1][DIV_STAGES] > 32'h4000_0000 ? 32'h4000_0000
                                                                   : dv_q[1][DIV_STAGES]);
            e0_n_reg <= side_reg[NSIDE-1].e0;
            e1_n_reg <= side_reg[NSIDE-1].e1;
            dg_n_reg <= side_reg[NSIDE-1].degen;

            // gap: dot product, sum wraps at 64 bits, then round
            pr0_reg   <= e0_n_reg * n0_reg;
            pr1_reg   <= e1_n_reg * n1_reg;
            n0_p1_reg <= n0_reg;
            n1_p1_reg <= n1_reg;
            dg_p1_reg <= dg_n_reg;

            acc_reg   <= pr0_reg[63:0] + pr1_reg[63:0];
            n0_p2_reg <= n0_p1_reg;
            n1_p2_reg <= n1_p1_reg;
            dg_p2_reg <= dg_p1_reg;

            gap_p3_reg <= round_sat32(acc_reg, 1'b0);
            n0_p3_reg  <= n0_p2_reg;
            n1_p3_reg  <= n1_p2_reg;
            dg_p3_reg  <= dg_p2_reg;

            // penalty, gradient and hessian products
            pen_reg    <= gm_next * gm_next;
            ng0_reg    <= n0_p3_reg * gap_p3_reg;
            ng1_reg    <= n1_p3_reg * gap_p3_reg;
            hxx_reg    <= n0_p3_reg * n0_p3_reg;
            hxy_reg    <= n0_p3_reg * n1_p3_reg;
            hyy_reg    <= n1_p3_reg * n1_p3_reg;
            gap_p4_reg <= gap_p3_reg;
            n0_p4_reg  <= n0_p3_reg;
            n1_p4_reg  <= n1_p3_reg;
            dg_p4_reg  <= dg_p3_reg;

            out_reg <= out_next;
        end
    end

    assign gm_next = gap_p3_reg[31] ? 32'(-gap_p3_reg) : 32'(gap_p3_reg);

    // output gating: zero-length segment clears all, open gap clears the rest
    always_comb
    begin
        logic [31:0] hxx_r;
        logic [31:0] hyy_r;
        out_next = '0;
        hxx_r    = round_sat32(hxx_reg, 1'b0);
        hyy_r    = round_sat32(hyy_reg, 1'b0);
        if (dg_p4_reg)
        begin
            out_next.degenerate = 1'b1;
        end
        else
        begin
            out_next.penalty  = pen_reg[62:0];
            out_next.gap      = gap_p4_reg;
            out_next.normal_x = n0_p4_reg;
            out_next.normal_y = n1_p4_reg;
            if (gap_p4_reg[31])
            begin
                out_next.penetrating    = 1'b1;
                out_next.grad_surface_x = round_sat32(ng0_reg, 1'b1);
                out_next.grad_surface_y = round_sat32(ng1_reg, 1'b1);
                out_next.hess_xx        = hxx_r[30:0];
                out_next.hess_xy        = round_sat32(hxy_reg, 1'b0);
                out_next.hess_yy        = hyy_r[30:0];
            end
        end
    end

    // square root chain
    assign sq_s[0]    = s_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        spcp_sqrt_stage #(.STAGE(k)) u_sqrt (
            .clk      (clk),
            .en       (en),
            .s_in     (sq_s[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .s_reg    (sq_s[k+1]),
            .rem_reg  (sq_rem[k+1]),
            .root_reg (sq_root[k+1])
        );
    end

    // two divide chains, one per normal component
    for (genvar c = 0; c < 2; c++)
    begin : g_comp
        assign dv_rem[c][0] = {2'b00, dv_num[c][0][61:32]};
        assign dv_q[c][0]   = '0;
        for (genvar k = 0; k < DIV_STAGES; k++)
        begin : g_div
            spcp_div_stage #(.STAGE(k)) u_div (
                .clk     (clk),
                .en      (en),
                .num_in  (dv_num[c][k]),
                .den_in  (dv_den[c][k]),
                .rem_in  (dv_rem[c][k]),
                .q_in    (dv_q[c][k]),
                .num_reg (dv_num[c][k+1]),
                .den_reg (dv_den[c][k+1]),
                .rem_reg (dv_rem[c][k+1]),
                .q_reg   (dv_q[c][k+1])
            );
        end
    end

    `SPCP_ASSERT_NOW(a_degen_zero, result.valid && result.data.degenerate,
        !result.data.penetrating && result.data.gap == '0 && result.data.penalty == '0,
        "zero-length segment with nonzero result")
    `SPCP_ASSERT_NOW(a_open_zero, result.valid && !result.data.penetrating,
        result.data.hess_xx == '0 && result.data.grad_surface_x == '0,
        "open contact with nonzero gradient or hessian")
    `SPCP_ASSERT_NOW(a_pen_sign, result.valid && result.data.penetrating,
        result.data.gap[31] && !result.data.degenerate,
        "penetration flag without negative gap")
    `SPCP_ASSERT_NOW(a_unit_range, result.valid,
        result.data.normal_x <= 32'sh4000_0000 && result.data.normal_x >= -32'sh4000_0000,
        "normal component beyond one")
    `SPCP_ASSERT_NEXT(a_stall_hold, valid_reg[NST-1] && !result.ready,
        valid_reg[NST-1] && $stable(out_reg),
        "pending result changed during stall")

endmodule

FILE: tb/tb_top.sv
// testbench for the 2d node-to-segment contact gap block: directed table, then random triples
// depends on spcp_pkg, spcp_if and segment_point_contact_penalty
`timescale 1ns / 1ps
module tb_top;
    import spcp_pkg::*;

    localparam int  N_RANDOM     = 800;
    localparam int  N_DIRECTED   = 14;
    localparam int  WATCHDOG_MAX = 20000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  LONG_HOLD    = 200;
    localparam int  MODE_SRC_IDLE = 0;
    localparam int  MODE_DST_IDLE = 1;
    localparam int  MODE_NO_IDLE  = 2;

    logic clk;
    logic rst_n;

    spcp_in_if  item_ch ();
    spcp_out_if result_ch ();

    segment_point_contact_penalty u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // expected contact results, oldest first
    out_item_t contact_q[$];
    int        fail_count;
    int        sent_count;
    int        got_count;
    int        penetrating_count;
    int        degenerate_count;
    int        idle_mode;
    int        hold_cycles;
    bit        stim_done;
    int        quiet_cycles;

    // magnitude of a signed 64-bit value
    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // drop 30 fraction bits with round half away from zero, clamp to int32
    function automatic logic signed [63:0] round_clamp30(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = mag_of(v);
        r = (m + (64'd1 << 29)) >> 30;
        if (v < 0)
        begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            return -$signed(r);
        end
        if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        return $signed(r);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // contact gap, normal, penalty, gradient and hessian for one triple
    function automatic out_item_t contact_of(input in_item_t t);
        out_item_t             o;
        logic signed [63:0]    dx, dy, ex, ey, nx, ny, acc, g;
        logic [63:0]           ax, ay, r, q, gm;
        o  = '0;
        dx = 64'(t.second_x) - 64'(t.first_x);
        dy = 64'(t.second_y) - 64'(t.first_y);
        ex = 64'(t.point_x) - 64'(t.first_x);
        ey = 64'(t.point_y) - 64'(t.first_y);
        if (dx == 0 && dy == 0)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        ax = mag_of(dy);
        ay = mag_of(dx);
        if ((ax | ay) >= (64'd1 << 31))
        begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        else
            while ((ax | ay) < (64'd1 << 30))
            begin
                ax = ax << 1;
                ay = ay << 1;
            end
        r = int_sqrt(ax * ax + ay * ay);
        q = (ax * (64'd1 << 30) + (r >> 1)) / r;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        nx = $signed(q);
        q = (ay * (64'd1 << 30) + (r >> 1)) / r;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        ny = $signed(q);
        if (dy < 0) nx = -nx;
        if (dx > 0) ny = -ny;
        acc = ex * nx + ey * ny;
        g   = round_clamp30(acc);
        gm  = mag_of(g);
        o.penalty  = 63'(gm * gm);
        o.gap      = g[31:0];
        o.normal_x = nx[31:0];
        o.normal_y = ny[31:0];
        if (g < 0)
        begin
            o.penetrating    = 1'b1;
            o.grad_surface_x = 32'(round_clamp30(-(nx * g)));
            o.grad_surface_y = 32'(round_clamp30(-(ny * g)));
            o.hess_xx        = 31'(round_clamp30(nx * nx));
            o.hess_xy        = 32'(round_clamp30(nx * ny));
            o.hess_yy        = 31'(round_clamp30(ny * ny));
        end
        return o;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return 32'($signed($urandom_range(0, 200000)) - 100000) << 8;
            default: return $urandom;
        endcase
    endfunction

    // mostly genuine contacts: point near the segment, either side
    function automatic in_item_t rand_triple();
        in_item_t t;
        t.first_x  = rand_coord();
        t.first_y  = rand_coord();
        t.second_x = rand_coord();
        t.second_y = rand_coord();
        t.point_x  = rand_coord();
        t.point_y  = rand_coord();
        if ($urandom_range(0, 3) != 0)
        begin
            t.first_x  = 32'($signed($urandom_range(0, 4000000)) - 2000000) << 4;
            t.first_y  = 32'($signed($urandom_range(0, 4000000)) - 2000000) << 4;
            t.second_x = t.first_x + 32'($signed($urandom_range(0, 400000)) - 200000);
            t.second_y = t.first_y + 32'($signed($urandom_range(0, 400000)) - 200000);
            t.point_x  = t.first_x + 32'($signed($urandom_range(0, 400000)) - 200000);
            t.point_y  = t.first_y + 32'($signed($urandom_range(0, 400000)) - 200000);
        end
        if ($urandom_range(0, 40) == 0)
        begin
            t.second_x = t.first_x;
            t.second_y = t.first_y;
        end
        return t;
    endfunction

    // directed table: zero-length segment, axis segments, touching, extremes
    in_item_t  dir_item[N_DIRECTED];
    out_item_t dir_want[N_DIRECTED];
    bit        dir_typed[N_DIRECTED];

    task automatic fill_table();
        out_item_t w;
        for (int i = 0; i < N_DIRECTED; i++) dir_typed[i] = 1'b0;
        // zero-length segment at the origin
        dir_item[0] = '{0, 0, 0, 0, 32'h0001_0000, 0};
        w = '0; w.degenerate = 1'b1;
        dir_want[0] = w; dir_typed[0] = 1'b1;
        // zero-length segment at the corners of the range
        dir_item[1] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000};
        dir_want[1] = w; dir_typed[1] = 1'b1;
        // segment along +x, point on the segment: gap zero, normal (0,-1)
        dir_item[2] = '{0, 0, 32'h0001_0000, 0, 32'h0000_8000, 0};
        w = '0; w.normal_y = -32'sd1073741824;
        dir_want[2] = w; dir_typed[2] = 1'b1;
        // segment along +x, point below: open side with normal (0,-1), gap +1
        dir_item[3] = '{0, 0, 32'h0001_0000, 0, 0, -32'sh0001_0000};
        w = '0; w.normal_y = -32'sd1073741824; w.gap = 32'h0001_0000;
        w.penalty = 63'h1_0000_0000;
        dir_want[3] = w; dir_typed[3] = 1'b1;
        // segment along +x, point above: penetrating, gap -1
        dir_item[4] = '{0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000};
        w = '0; w.penetrating = 1'b1; w.normal_y = -32'sd1073741824;
        w.gap = -32'sh0001_0000; w.penalty = 63'h1_0000_0000;
        w.grad_surface_y = -32'sh0001_0000; w.hess_yy = 31'h4000_0000;
        dir_want[4] = w; dir_typed[4] = 1'b1;
        // segment along +y, point at -x: penetrating along normal (1,0)
        dir_item[5] = '{0, 0, 0, 32'h0001_0000, -32'sh0001_0000, 0};
        w = '0; w.penetrating = 1'b1; w.normal_x = 32'sd1073741824;
        w.gap = -32'sh0001_0000; w.penalty = 63'h1_0000_0000;
        w.grad_surface_x = 32'h0001_0000; w.hess_xx = 31'h4000_0000;
        dir_want[5] = w; dir_typed[5] = 1'b1;
        // widest segment, point far away: gap saturation
        dir_item[6]  = '{32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF};
        dir_item[7]  = '{32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000};
        dir_item[8]  = '{0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0};
        dir_item[9]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF};
        // diagonal, one lsb segments and all-ones bit patterns
        dir_item[10] = '{0, 0, 1, 1, 0, 1};
        dir_item[11] = '{0, 0, 32'hFFFF_FFFF, 1, 1, 1};
        dir_item[12] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'hFFFF_FFFF, 32'h0000_0000};
        dir_item[13] = '{32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                         32'h7FFF_FFFF, 32'h8000_0001};
    endtask

    // offer one triple and wait for its transfer; returns at a falling edge
    // with valid still high so that triples can follow back to back
    task automatic send_triple(input in_item_t t, input out_item_t want);
        while (((idle_mode == MODE_SRC_IDLE) && ($urandom_range(0, 99) < 16)) ||
               ((idle_mode == MODE_DST_IDLE) && ($urandom_range(0, 99) < 71)))
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= t;
        do
            @(posedge clk);
        while (!item_ch.ready);
        contact_q.insert(contact_q.size(), want);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (contact_q.size() != 0)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        in_item_t t;
        fail_count  = 0;
        sent_count  = 0;
        stim_done   = 1'b0;
        idle_mode   = MODE_SRC_IDLE;
        hold_cycles = 0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        fill_table();
        for (int i = 0; i < N_DIRECTED; i++)
            send_triple(dir_item[i],
                        dir_typed[i] ? dir_want[i] : contact_of(dir_item[i]));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                // pause until everything is back, then swap idling roles
                item_ch.valid <= 1'b0;
                @(negedge clk);
                wait_drained();
                idle_mode = MODE_DST_IDLE;
            end
            if (i == 2 * N_RANDOM / 3)
            begin
                idle_mode   = MODE_NO_IDLE;
                hold_cycles = LONG_HOLD;
            end
            t = rand_triple();
            send_triple(t, contact_of(t));
        end
        item_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side: ready pattern and long hold-off, counted here
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else if (idle_mode == MODE_DST_IDLE)
                result_ch.ready <= ($urandom_range(0, 99) >= 16);
            else if (idle_mode == MODE_SRC_IDLE)
                result_ch.ready <= ($urandom_range(0, 99) >= 71);
            else
                result_ch.ready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t w;
        out_item_t a;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            a = result_ch.data;
            got_count++;
            if (contact_q.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                fail_count++;
            end
            else
            begin
                w = contact_q.pop_front();
                if (a.penetrating) penetrating_count++;
                if (a.degenerate) degenerate_count++;
                if (a.penetrating !== w.penetrating)
                begin $error("penetrating exp %0d got %0d", w.penetrating, a.penetrating);
                    fail_count++; end
                if (a.degenerate !== w.degenerate)
                begin $error("degenerate exp %0d got %0d", w.degenerate, a.degenerate);
                    fail_count++; end
                if (a.penalty !== w.penalty)
                begin $error("penalty exp %h got %h", w.penalty, a.penalty);
                    fail_count++; end
                if (a.gap !== w.gap)
                begin $error("gap exp %h got %h", w.gap, a.gap); fail_count++; end
                if (a.normal_x !== w.normal_x)
                begin $error("normal_x exp %h got %h", w.normal_x, a.normal_x);
                    fail_count++; end
                if (a.normal_y !== w.normal_y)
                begin $error("normal_y exp %h got %h", w.normal_y, a.normal_y);
                    fail_count++; end
                if (a.grad_surface_x !== w.grad_surface_x)
                begin $error("grad_surface_x exp %h got %h", w.grad_surface_x,
                             a.grad_surface_x); fail_count++; end
                if (a.grad_surface_y !== w.grad_surface_y)
                begin $error("grad_surface_y exp %h got %h", w.grad_surface_y,
                             a.grad_surface_y); fail_count++; end
                if (a.hess_xx !== w.hess_xx)
                begin $error("hess_xx exp %h got %h", w.hess_xx, a.hess_xx);
                    fail_count++; end
                if (a.hess_xy !== w.hess_xy)
                begin $error("hess_xy exp %h got %h", w.hess_xy, a.hess_xy);
                    fail_count++; end
                if (a.hess_yy !== w.hess_yy)
                begin $error("hess_yy exp %h got %h", w.hess_yy, a.hess_yy);
                    fail_count++; end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        got_count = 0;
        penetrating_count = 0;
        degenerate_count  = 0;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("[segment_point_contact_penalty] ERROR");
                $finish;
            end
        end
    end

    // end of run: drain, then allow the pipe latency to pass
    initial
    begin
        wait (stim_done);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (contact_q.size() != 0)
        begin
            $error("%0d expected results left over", contact_q.size());
            fail_count++;
        end
        $display("covered %0d triples, %0d results, %0d penetrating, %0d degenerate",
                 sent_count, got_count, penetrating_count, degenerate_count);
        if (fail_count == 0)
            $display("[segment_point_contact_penalty] OK");
        else
            $display("[segment_point_contact_penalty] ERROR");
        $finish;
    end

endmodule
